FILE: src/bpge_pkg.sv
`default_nettype none
package bpge_pkg;

  // Store geometry
  localparam int NODES      = 4096;
  localparam int PW         = 64;              // pattern bits per node word
  localparam int ADDR_W     = $clog2(NODES);
  localparam int NODE_W     = 12;              // width of the node fields
  localparam int NODE_EXT_W = 17;              // wide enough for any NODES index
  localparam int WORD_W     = 64;              // width of the word fields

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_FANIN  = 2'd1,
    REQ_READ   = 2'd2,
    REQ_BACKUP = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    GF_BUF  = 4'd0,
    GF_NOT  = 4'd1,
    GF_AND  = 4'd2,
    GF_OR   = 4'd3,
    GF_NAND = 4'd4,
    GF_NOR  = 4'd5,
    GF_XOR  = 4'd6,
    GF_XNOR = 4'd7,
    GF_MUX  = 4'd8
  } gate_fn_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_in;      // write request accepted this cycle
    logic issue;      // other request accepted: capture fields, start store reads
    logic rd_fanin;   // address value store with the fanin node
    logic fold;       // fold the read word into the accumulator
    logic backup;     // copy the read word into the backup store
    logic load_out;   // load the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register can take a word this cycle
  } sts_t;

endpackage
`default_nettype wire

FILE: src/bpge_ctrl.sv
`default_nettype none
module bpge_ctrl
  import bpge_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_req_type,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  req_t   req_r, req_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    req_nxt      = req_r;
    cmd.rd_fanin = (req_t'(in_req_type) == REQ_FANIN);
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (req_t'(in_req_type) == REQ_WRITE) begin
            cmd.wr_in = 1'b1;
          end else begin
            cmd.issue = 1'b1;
            req_nxt   = req_t'(in_req_type);
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        case (req_r)
          REQ_FANIN: begin
            cmd.fold  = 1'b1;
            state_nxt = S_IDLE;
          end
          REQ_BACKUP: begin
            cmd.backup = 1'b1;
            state_nxt  = S_IDLE;
          end
          REQ_READ: begin
            if (sts.out_free) begin
              cmd.load_out = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      req_r   <= REQ_WRITE;
    end else begin
      state_r <= state_nxt;
      req_r   <= req_nxt;
    end
  end

  // a non-write request always takes the execute cycle
  a_exec_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |=> !in_ready)
    else $error("input taken during execute cycle");

endmodule
`default_nettype wire

FILE: src/bpge_dp.sv
`default_nettype none
module bpge_dp
  import bpge_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic [NODE_W-1:0] in_node,
  input  wire logic [NODE_W-1:0] in_fanin_node,
  input  wire logic [3:0]        in_gate_function,
  input  wire logic              in_last_fanin,
  input  wire logic [WORD_W-1:0] in_write_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      out_read_word,
  output logic [WORD_W-1:0]      out_backup_word
);

  logic [PW-1:0] vmem [NODES];
  logic [PW-1:0] bmem [NODES];

  logic [NODE_EXT_W-1:0] node_ext, fin_ext;
  logic [ADDR_W-1:0]     in_addr, fin_addr, rd_addr;
  logic                  in_ok, fin_ok;

  // captured request
  logic [ADDR_W-1:0] node_r;
  logic              node_ok_r, fin_ok_r, last_r;
  gate_fn_t          fn_r;
  logic [PW-1:0]     vrd_r, brd_r;

  // gate state
  logic [PW-1:0] acc_r, acc_nxt, sel_r, sel_nxt;
  logic [1:0]    pos_r, pos_nxt;
  logic [PW-1:0] v, res;
  logic          store_we;

  // value store write port
  logic              v_we;
  logic [ADDR_W-1:0] v_waddr;
  logic [PW-1:0]     v_wdata;

  logic              out_valid_r;
  logic [WORD_W-1:0] rd_word_r, bk_word_r;

  assign node_ext = NODE_EXT_W'(in_node);
  assign fin_ext  = NODE_EXT_W'(in_fanin_node);
  assign in_addr  = node_ext[ADDR_W-1:0];
  assign fin_addr = fin_ext[ADDR_W-1:0];
  assign in_ok    = node_ext < NODE_EXT_W'(NODES);
  assign fin_ok   = fin_ext < NODE_EXT_W'(NODES);
  assign rd_addr  = cmd.rd_fanin ? fin_addr : in_addr;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      node_r    <= in_addr;
      node_ok_r <= in_ok;
      fin_ok_r  <= fin_ok;
      fn_r      <= gate_fn_t'(in_gate_function);
      last_r    <= in_last_fanin;
    end
  end

  // fanin fold
  assign v = fin_ok_r ? vrd_r : '0;

  always_comb begin
    acc_nxt = acc_r;
    sel_nxt = sel_r;
    case (fn_r)
      GF_BUF, GF_NOT: begin
        if (pos_r == 2'd0) acc_nxt = v;
      end
      GF_AND, GF_NAND: begin
        acc_nxt = ((pos_r == 2'd0) ? {PW{1'b1}} : acc_r) & v;
      end
      GF_OR, GF_NOR: begin
        acc_nxt = ((pos_r == 2'd0) ? {PW{1'b0}} : acc_r) | v;
      end
      GF_XOR, GF_XNOR: begin
        if (pos_r == 2'd0)      acc_nxt = v;
        else if (pos_r == 2'd1) acc_nxt = acc_r ^ v;
      end
      GF_MUX: begin
        if (pos_r == 2'd0) begin
          sel_nxt = v;
          acc_nxt = '0;
        end else if (pos_r == 2'd1) begin
          acc_nxt = acc_r | (v & ~sel_r);
        end else if (pos_r == 2'd2) begin
          acc_nxt = acc_r | (v & sel_r);
        end
      end
      default: begin
      end
    endcase

    if (last_r)               pos_nxt = 2'd0;
    else if (pos_r != 2'd3)   pos_nxt = pos_r + 2'd1;
    else                      pos_nxt = pos_r;

    if (fn_r == GF_NOT || fn_r == GF_NAND || fn_r == GF_NOR || fn_r == GF_XNOR) begin
      res = ~acc_nxt;
    end else begin
      res = acc_nxt;
    end
  end

  assign store_we = cmd.fold && last_r && node_ok_r && (fn_r <= GF_MUX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      sel_r <= '0;
      pos_r <= 2'd0;
    end else if (cmd.fold) begin
      acc_r <= acc_nxt;
      sel_r <= sel_nxt;
      pos_r <= pos_nxt;
    end
  end

  // value store: one write, one registered read
  assign v_we    = (cmd.wr_in && in_ok) || store_we;
  assign v_waddr = cmd.wr_in ? in_addr : node_r;
  assign v_wdata = cmd.wr_in ? in_write_word[PW-1:0] : res;

  always_ff @(posedge clk) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) vrd_r <= vmem[rd_addr];
  end

  // backup store
  always_ff @(posedge clk) begin
    if (cmd.backup && node_ok_r) bmem[node_r] <= vrd_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) brd_r <= bmem[in_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rd_word_r <= node_ok_r ? WORD_W'(vrd_r) : '0;
      bk_word_r <= node_ok_r ? WORD_W'(brd_r) : '0;
    end
  end

  assign sts.out_free     = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_read_word    = rd_word_r;
  assign out_backup_word  = bk_word_r;

  a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_in && store_we))
    else $error("value store written twice in one cycle");

  a_pos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fold && last_r) |=> (pos_r == 2'd0))
    else $error("fanin position not cleared after last fanin");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_out))
    else $error("result shown without a read");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

FILE: src/bit_parallel_gate_evaluator_unit.sv
// Timing: a write request lands in the value store at its accept edge; a read
// request has its store read registered at the accept edge, then the execute
// state loads the output register once that register is free.
// Throughput: one write per cycle while the controller is idle; fanin, read and
// backup requests each hold in_ready low through an execute state after the store read.
// Reset: clears controller, accumulator, mux select, fanin position and output
// valid; the value and backup stores are not cleared (undefined until written).
`default_nettype none
module bit_parallel_gate_evaluator_unit
  import bpge_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [NODE_W-1:0] in_node,
  input  wire logic [NODE_W-1:0] in_fanin_node,
  input  wire logic [3:0]        in_gate_function,
  input  wire logic              in_last_fanin,
  input  wire logic [WORD_W-1:0] in_write_word,
  // result channel (read requests only)
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      out_read_word,
  output logic [WORD_W-1:0]      out_backup_word
);

  cmd_t cmd;
  sts_t sts;

  // Controller: idle/execute sequencer. Writes retire in the accept cycle;
  // every other request spends an execute state after its store read.
  bpge_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Datapath: value and backup stores, gate accumulator, output register.
  // The output register lets a new request in while a read result waits.
  bpge_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_node          (in_node),
    .in_fanin_node    (in_fanin_node),
    .in_gate_function (in_gate_function),
    .in_last_fanin    (in_last_fanin),
    .in_write_word    (in_write_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_word    (out_read_word),
    .out_backup_word  (out_backup_word)
  );

endmodule
`default_nettype wire
